// ===== design/ftt_pkg.sv =====
// Shared types, widths and constants of the fixed timestep frame timer.
// Used by ftt_alu, ftt_ctrl and the top level; depends on nothing.
`default_nettype none

package ftt_pkg;

  // Field and state widths
  localparam int unsigned DELTA_W = 48;
  localparam int unsigned TGT_W   = 32;
  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned LEFT_W  = 49;
  localparam int unsigned SEC_W   = 49;
  localparam int unsigned ALU_W   = 50;
  localparam int unsigned MUL_W   = 32;
  localparam int unsigned PROD_W  = 64;

  // Timing constants
  localparam int unsigned TICKS_PER_SEC = 10000000;
  localparam int unsigned SNAP_TICKS    = TICKS_PER_SEC / 4000;
  localparam int unsigned MAX_STEPS_DEF = 32;

  // sec / TICKS_PER_SEC ~= ((sec >> SEC_SHIFT) * SEC_RECIP) >> RECIP_SHIFT,
  // never high and at most one low; SEC_RECIP = floor(2^55 / TICKS_PER_SEC)
  localparam int unsigned      SEC_SHIFT   = 17;
  localparam int unsigned      RECIP_SHIFT = 38;
  localparam logic [MUL_W-1:0] SEC_RECIP   = 32'd3602879701;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA   = 2'd2;

  localparam logic [TGT_W-1:0]   TARGET_RST    = 32'd166666;
  localparam logic [DELTA_W-1:0] MAX_DELTA_RST = 48'd3139180000000;

  // Input item mode codes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_RESET = 1'b1;

  typedef struct packed {
    logic               fixed_mode;
    logic [TGT_W-1:0]   target_step_ticks;
    logic [DELTA_W-1:0] max_delta_ticks;
  } cfg_t;

  typedef struct packed {
    logic               stepped;
    logic [DELTA_W-1:0] step_ticks;
    logic [TOTAL_W-1:0] elapsed_sum;
    logic [CNT_W-1:0]   step_count;
    logic [CNT_W-1:0]   frames_per_second;
    logic               last;
  } result_t;

  // Shared add/subtract unit request and response
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic             carry;
    logic [ALU_W-1:0] sum;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== design/fixed_timestep_frame_timer_unit.sv =====
// Top level of the fixed timestep frame timer: config registers, output register.
// Depends on ftt_pkg, ftt_alu and ftt_ctrl.
//
//   Channel  Handshake                 Payload
//   in       in_valid_i / in_ready_o   mode_i, delta_ticks_i
//   out      out_valid_o / out_ready_i stepped_o .. last_o (one per step, at least one)
//   cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A reset item goes straight to EMIT. A tick runs SEC and CLAMP, then RATE in
// variable mode; fixed mode runs SNAP_A, SNAP_B when needed, ACC, and STEP for
// each step taken (up to MAX_STEPS) and a final check, skipping STEP with a zero
// target. A completed wall second adds QEST, QMUL, REM and FIX for the remainder.
// Results wait in EMIT; the states share the add/subtract unit; one item is in flight.
// Reset is asynchronous, active low; the output register decouples stalls on
// out, and the next item is taken while the last result waits there.
`default_nettype none

module fixed_timestep_frame_timer_unit #(
  parameter int unsigned MAX_STEPS = ftt_pkg::MAX_STEPS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire                                mode_i,
  input  wire [ftt_pkg::DELTA_W-1:0]         delta_ticks_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic                               stepped_o,
  output logic [ftt_pkg::DELTA_W-1:0]        step_ticks_o,
  output logic [ftt_pkg::TOTAL_W-1:0]        elapsed_sum_o,
  output logic [ftt_pkg::CNT_W-1:0]          step_count_o,
  output logic [ftt_pkg::CNT_W-1:0]          frames_per_second_o,
  output logic                               last_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [ftt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [ftt_pkg::DELTA_W-1:0]         cfg_data_i
);

  ftt_pkg::cfg_t     cfg_q;
  ftt_pkg::alu_req_t alu_req;
  ftt_pkg::alu_rsp_t alu_rsp;
  ftt_pkg::result_t  res;
  ftt_pkg::result_t  out_q;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fixed_mode        <= 1'b0;
      cfg_q.target_step_ticks <= ftt_pkg::TARGET_RST;
      cfg_q.max_delta_ticks   <= ftt_pkg::MAX_DELTA_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ftt_pkg::CFG_FIXED_MODE:  cfg_q.fixed_mode        <= cfg_data_i[0];
        ftt_pkg::CFG_TARGET_STEP: cfg_q.target_step_ticks <= cfg_data_i[ftt_pkg::TGT_W-1:0];
        ftt_pkg::CFG_MAX_DELTA:   cfg_q.max_delta_ticks   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ftt_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  ftt_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .delta_ticks_i (delta_ticks_i),
    .alu_req_o     (alu_req),
    .alu_rsp_i     (alu_rsp),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign stepped_o           = out_q.stepped;
  assign step_ticks_o        = out_q.step_ticks;
  assign elapsed_sum_o       = out_q.elapsed_sum;
  assign step_count_o        = out_q.step_count;
  assign frames_per_second_o = out_q.frames_per_second;
  assign last_o              = out_q.last;

endmodule

`default_nettype wire

// ===== design/ftt_alu.sv =====
// Shared add/subtract/compare unit of the frame timer.
// Depends on ftt_pkg for the request and response types.
`default_nettype none

module ftt_alu (
  input  wire ftt_pkg::alu_req_t req_i,
  output ftt_pkg::alu_rsp_t      rsp_o
);

  logic [ftt_pkg::ALU_W-1:0] b_op;
  logic [ftt_pkg::ALU_W:0]   full;

  // a + b, or a + ~b + 1; carry out is a >= b when subtracting
  assign b_op  = req_i.sub ? ~req_i.b : req_i.b;
  assign full  = {1'b0, req_i.a} + {1'b0, b_op} + {{ftt_pkg::ALU_W{1'b0}}, req_i.sub};
  assign rsp_o = '{carry: full[ftt_pkg::ALU_W], sum: full[ftt_pkg::ALU_W-1:0]};

endmodule

`default_nettype wire

// ===== design/ftt_ctrl.sv =====
// Sequencer and timer state of the frame timer; drives the shared ALU.
// Depends on ftt_pkg; the top level supplies config and takes results.
`default_nettype none

module ftt_ctrl #(
  parameter int unsigned MAX_STEPS = ftt_pkg::MAX_STEPS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire ftt_pkg::cfg_t                cfg_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire                               mode_i,
  input  wire [ftt_pkg::DELTA_W-1:0]        delta_ticks_i,
  output ftt_pkg::alu_req_t                 alu_req_o,
  input  wire ftt_pkg::alu_rsp_t            alu_rsp_i,
  output logic                              res_valid_o,
  input  wire                               res_ready_i,
  output ftt_pkg::result_t                  res_o
);

  localparam int unsigned N_W = $clog2(MAX_STEPS + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SEC    = 4'd1;
  localparam logic [3:0] ST_CLAMP  = 4'd2;
  localparam logic [3:0] ST_SNAP_A = 4'd3;
  localparam logic [3:0] ST_SNAP_B = 4'd4;
  localparam logic [3:0] ST_ACC    = 4'd5;
  localparam logic [3:0] ST_STEP   = 4'd6;
  localparam logic [3:0] ST_RATE   = 4'd7;
  localparam logic [3:0] ST_QEST   = 4'd8;
  localparam logic [3:0] ST_EMIT   = 4'd9;
  localparam logic [3:0] ST_QMUL   = 4'd10;
  localparam logic [3:0] ST_REM    = 4'd11;
  localparam logic [3:0] ST_FIX    = 4'd12;

  logic [3:0]                    state_q;
  logic [ftt_pkg::DELTA_W-1:0]   delta_q;
  logic [ftt_pkg::SEC_W-1:0]     sec_q;
  logic [ftt_pkg::DELTA_W-1:0]   dt_q;
  logic [ftt_pkg::LEFT_W-1:0]    leftover_q;
  logic [N_W-1:0]                n_q;
  logic [ftt_pkg::PROD_W-1:0]    prod_q;
  logic [ftt_pkg::FRAC_W-1:0]    sf_q;
  logic [ftt_pkg::CNT_W-1:0]     fis_q;
  logic [ftt_pkg::CNT_W-1:0]     rate_q;
  logic [ftt_pkg::DELTA_W-1:0]   step_len_q;
  logic [ftt_pkg::TOTAL_W-1:0]   total_q;
  logic [ftt_pkg::CNT_W-1:0]     frames_q;

  logic                          ge;
  logic [ftt_pkg::DELTA_W-1:0]   tgt_ext;
  logic [ftt_pkg::DELTA_W-1:0]   len;
  logic [ftt_pkg::TOTAL_W-1:0]   total_nxt;
  logic [ftt_pkg::CNT_W-1:0]     fis_sum;
  logic [ftt_pkg::MUL_W-1:0]     mul_a;
  logic [ftt_pkg::MUL_W-1:0]     mul_b;
  logic [ftt_pkg::PROD_W-1:0]    mul_p;
  logic                          snap_hit;
  logic                          has_step;

  assign ge        = alu_rsp_i.carry;
  assign tgt_ext   = ftt_pkg::DELTA_W'(cfg_i.target_step_ticks);
  assign len       = cfg_i.fixed_mode ? tgt_ext : dt_q;
  assign total_nxt = total_q + ftt_pkg::TOTAL_W'(len);
  assign fis_sum   = fis_q + ftt_pkg::CNT_W'(n_q);
  assign snap_hit  = alu_rsp_i.sum[ftt_pkg::DELTA_W-1:0]
                     < ftt_pkg::DELTA_W'(ftt_pkg::SNAP_TICKS);
  assign has_step  = (n_q != '0);

  // Shared multiplier: quotient estimate first, then quotient times one second
  assign mul_a = (state_q == ST_QMUL)
                 ? ftt_pkg::MUL_W'(prod_q[ftt_pkg::PROD_W-1:ftt_pkg::RECIP_SHIFT])
                 : sec_q[ftt_pkg::SEC_W-1:ftt_pkg::SEC_SHIFT];
  assign mul_b = (state_q == ST_QMUL) ? ftt_pkg::MUL_W'(ftt_pkg::TICKS_PER_SEC)
                                      : ftt_pkg::SEC_RECIP;
  assign mul_p = {{ftt_pkg::MUL_W{1'b0}}, mul_a} * {{ftt_pkg::MUL_W{1'b0}}, mul_b};

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);

  // Result seen after this step is applied
  always_comb begin
    res_o.stepped           = has_step;
    res_o.step_ticks        = has_step ? len : step_len_q;
    res_o.elapsed_sum       = has_step ? total_nxt : total_q;
    res_o.step_count        = has_step ? frames_q + 1'b1 : frames_q;
    res_o.frames_per_second = rate_q;
    res_o.last              = (n_q <= N_W'(1));
  end

  // Operand select for the shared unit
  always_comb begin
    alu_req_o = '0;
    case (state_q)
      ST_SEC: begin
        alu_req_o.a = ftt_pkg::ALU_W'(sf_q);
        alu_req_o.b = ftt_pkg::ALU_W'(delta_q);
      end
      ST_CLAMP: begin
        alu_req_o.a   = ftt_pkg::ALU_W'(delta_q);
        alu_req_o.b   = ftt_pkg::ALU_W'(cfg_i.max_delta_ticks);
        alu_req_o.sub = 1'b1;
      end
      ST_SNAP_A: begin
        alu_req_o.a   = ftt_pkg::ALU_W'(dt_q);
        alu_req_o.b   = ftt_pkg::ALU_W'(tgt_ext);
        alu_req_o.sub = 1'b1;
      end
      ST_SNAP_B: begin
        alu_req_o.a   = ftt_pkg::ALU_W'(tgt_ext);
        alu_req_o.b   = ftt_pkg::ALU_W'(dt_q);
        alu_req_o.sub = 1'b1;
      end
      ST_ACC: begin
        alu_req_o.a = ftt_pkg::ALU_W'(leftover_q);
        alu_req_o.b = ftt_pkg::ALU_W'(dt_q);
      end
      ST_STEP: begin
        alu_req_o.a   = ftt_pkg::ALU_W'(leftover_q);
        alu_req_o.b   = ftt_pkg::ALU_W'(tgt_ext);
        alu_req_o.sub = 1'b1;
      end
      ST_RATE: begin
        alu_req_o.a   = ftt_pkg::ALU_W'(sec_q);
        alu_req_o.b   = ftt_pkg::ALU_W'(ftt_pkg::TICKS_PER_SEC);
        alu_req_o.sub = 1'b1;
      end
      ST_REM: begin
        alu_req_o.a   = ftt_pkg::ALU_W'(sec_q);
        alu_req_o.b   = ftt_pkg::ALU_W'(prod_q[ftt_pkg::SEC_W-1:0]);
        alu_req_o.sub = 1'b1;
      end
      ST_FIX: begin
        alu_req_o.a   = ftt_pkg::ALU_W'(sec_q);
        alu_req_o.b   = ftt_pkg::ALU_W'(ftt_pkg::TICKS_PER_SEC);
        alu_req_o.sub = 1'b1;
      end
      default: alu_req_o = '0;
    endcase
  end

  // Payload latches for the current item
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      delta_q <= delta_ticks_i;
    end
    if (state_q == ST_SEC || state_q == ST_REM) begin
      sec_q <= alu_rsp_i.sum[ftt_pkg::SEC_W-1:0];
    end
    if (state_q == ST_QEST || state_q == ST_QMUL) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_CLAMP) begin
      dt_q <= ge ? cfg_i.max_delta_ticks : delta_q;
    end else if ((state_q == ST_SNAP_A && ge && snap_hit) ||
                 (state_q == ST_SNAP_B && snap_hit)) begin
      dt_q <= tgt_ext;
    end
  end

  // Sequencer and timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      leftover_q <= '0;
      n_q        <= '0;
      sf_q       <= '0;
      fis_q      <= '0;
      rate_q     <= '0;
      step_len_q <= '0;
      total_q    <= '0;
      frames_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            n_q <= '0;
            if (mode_i == ftt_pkg::MODE_RESET) begin
              leftover_q <= '0;
              rate_q     <= '0;
              fis_q      <= '0;
              sf_q       <= '0;
              state_q    <= ST_EMIT;
            end else begin
              state_q <= ST_SEC;
            end
          end
        end
        ST_SEC: state_q <= ST_CLAMP;
        ST_CLAMP: begin
          if (cfg_i.fixed_mode) begin
            state_q <= ST_SNAP_A;
          end else begin
            leftover_q <= '0;
            n_q        <= N_W'(1);
            state_q    <= ST_RATE;
          end
        end
        ST_SNAP_A: state_q <= ge ? ST_ACC : ST_SNAP_B;
        ST_SNAP_B: state_q <= ST_ACC;
        ST_ACC: begin
          // saturate the leftover at its full scale
          leftover_q <= alu_rsp_i.sum[ftt_pkg::LEFT_W] ? '1
                        : alu_rsp_i.sum[ftt_pkg::LEFT_W-1:0];
          state_q    <= (cfg_i.target_step_ticks != '0) ? ST_STEP : ST_RATE;
        end
        ST_STEP: begin
          if (ge && n_q < N_W'(MAX_STEPS)) begin
            leftover_q <= alu_rsp_i.sum[ftt_pkg::LEFT_W-1:0];
            n_q        <= n_q + 1'b1;
          end else begin
            state_q <= ST_RATE;
          end
        end
        ST_RATE: begin
          if (ge) begin
            rate_q  <= fis_sum;
            fis_q   <= '0;
            state_q <= ST_QEST;
          end else begin
            fis_q   <= fis_sum;
            sf_q    <= sec_q[ftt_pkg::FRAC_W-1:0];
            state_q <= ST_EMIT;
          end
        end
        // remainder of a second: reciprocal estimate, back-multiply, one fix-up
        ST_QEST: state_q <= ST_QMUL;
        ST_QMUL: state_q <= ST_REM;
        ST_REM:  state_q <= ST_FIX;
        ST_FIX: begin
          sf_q    <= ge ? alu_rsp_i.sum[ftt_pkg::FRAC_W-1:0]
                        : sec_q[ftt_pkg::FRAC_W-1:0];
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_ready_i) begin
            if (has_step) begin
              step_len_q <= len;
              total_q    <= total_nxt;
              frames_q   <= frames_q + 1'b1;
              n_q        <= n_q - 1'b1;
            end
            if (n_q <= N_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_step_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= N_W'(MAX_STEPS))
    else $error("step count above cap");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (sf_q < ftt_pkg::FRAC_W'(ftt_pkg::TICKS_PER_SEC)))
    else $error("second remainder out of range");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i && res_o.last) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after last result");

  a_left_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |=> (leftover_q <= $past(leftover_q)))
    else $error("leftover grew while taking steps");
`endif

endmodule

`default_nettype wire
